// ===== rtl/pdri_pkg.sv =====
// Shared types and constants for the palette DAC register interface.
// No dependencies; imported by every other file of the block.
package pdri_pkg;

	localparam int ADDR_W  = 8;
	localparam int COLOR_W = 24;
	localparam int BYTE_W  = 8;

	// request types
	localparam logic [1:0] REQ_READ   = 2'd0;
	localparam logic [1:0] REQ_WRITE  = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	// register selects
	localparam logic [1:0] SEL_ADDR = 2'd0;
	localparam logic [1:0] SEL_DATA = 2'd1;
	localparam logic [1:0] SEL_PBC  = 2'd2;

	// color component step
	localparam logic [1:0] STEP_RED   = 2'd0;
	localparam logic [1:0] STEP_GREEN = 2'd1;
	localparam logic [1:0] STEP_BLUE  = 2'd2;
	localparam logic [1:0] STEP_DONE  = 2'd3;

	// pixel bus control bits 4:2 codes
	localparam logic [2:0] PBC_1BPP  = 3'b000;
	localparam logic [2:0] PBC_2BPP  = 3'b010;
	localparam logic [2:0] PBC_4BPP  = 3'b100;
	localparam logic [2:0] PBC_8BPP  = 3'b110;
	localparam logic [2:0] PBC_24BPP = 3'b111;

	// depth modes
	localparam logic [2:0] DEPTH_1BPP  = 3'd0;
	localparam logic [2:0] DEPTH_2BPP  = 3'd1;
	localparam logic [2:0] DEPTH_4BPP  = 3'd2;
	localparam logic [2:0] DEPTH_8BPP  = 3'd3;
	localparam logic [2:0] DEPTH_24BPP = 3'd4;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [1:0]        reg_select;
		logic [BYTE_W-1:0] write_data;
		logic [ADDR_W-1:0] pixel_index;
	} pdri_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  read_data;
		logic [COLOR_W-1:0] pixel_color;
		logic [2:0]         depth_mode;
	} pdri_rsp_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} pdri_rd_t;

	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] data;
	} pdri_wr_t;

endpackage

// ===== rtl/pdri_palette_ram.sv =====
// Palette color store: synchronous RAM with a registered read plus
// per-entry valid bits so unwritten entries read as black. Uses pdri_pkg.
module pdri_palette_ram #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pdri_pkg::pdri_rd_t             rd_req,
	input  pdri_pkg::pdri_wr_t             wr_req,
	output logic [pdri_pkg::COLOR_W-1:0]   rd_data
);
	import pdri_pkg::*;

	localparam int AW = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;

	logic [COLOR_W-1:0]         mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] vld_q;
	logic [COLOR_W-1:0]         rd_data_q;
	logic                       rd_hit_q;
	logic [AW-1:0]              rd_idx;
	logic [AW-1:0]              wr_idx;
	logic                       rd_in;
	logic                       wr_in;

	assign rd_idx = rd_req.addr[AW-1:0];
	assign wr_idx = wr_req.addr[AW-1:0];
	// indexes at or above the depth name no entry
	assign rd_in  = {1'b0, rd_req.addr} < (ADDR_W+1)'(PALETTE_ENTRIES);
	assign wr_in  = {1'b0, wr_req.addr} < (ADDR_W+1)'(PALETTE_ENTRIES);

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data_q <= mem[rd_idx];
		end
		if (wr_req.en && wr_in) begin
			mem[wr_idx] <= wr_req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_req.en && wr_in) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_req.en) begin
				rd_hit_q <= rd_in && vld_q[rd_idx];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

endmodule

// ===== rtl/pdri_ctrl.sv =====
// Register file and read-modify-write sequencer: palette pointer, component
// step, pixel bus control, depth mode and the result word. Uses pdri_pkg.
module pdri_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pdri_pkg::pdri_cmd_t           cmd,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	output logic                          done,
	output pdri_pkg::pdri_rsp_t           rsp,
	output pdri_pkg::pdri_rd_t            rd_req,
	output pdri_pkg::pdri_wr_t            wr_req,
	input  logic [pdri_pkg::COLOR_W-1:0]  rd_data
);
	import pdri_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              mono_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [1:0]        step_q;
	logic [BYTE_W-1:0] pbc_q;
	logic [2:0]        depth_q;
	pdri_cmd_t         cmd_s1;
	pdri_rsp_t         rsp_q;

	logic [ADDR_W-1:0] ptr_d;
	logic [1:0]        step_d;
	logic [BYTE_W-1:0] pbc_d;
	logic [2:0]        depth_d;
	logic [BYTE_W-1:0] rd_byte;
	logic [COLOR_W-1:0] color;
	logic [COLOR_W-1:0] merged;
	logic              wr_en;
	logic              accept;

	assign accept = start && !busy_q;

	// read issued on accept; data arrives in the busy cycle
	always_comb begin
		rd_req.en   = accept;
		rd_req.addr = (cmd.req_type == REQ_LOOKUP) ? cmd.pixel_index : ptr_q;
	end

	always_comb begin
		case (step_q)
			STEP_RED:   merged = {cmd_s1.write_data, rd_data[15:0]};
			STEP_GREEN: merged = {rd_data[23:16], cmd_s1.write_data, rd_data[7:0]};
			default:    merged = {rd_data[23:8], cmd_s1.write_data};
		endcase
	end

	always_comb begin
		ptr_d   = ptr_q;
		step_d  = step_q;
		pbc_d   = pbc_q;
		depth_d = depth_q;
		rd_byte = '0;
		color   = '0;
		wr_en   = 1'b0;
		case (cmd_s1.req_type)
			REQ_READ: begin
				case (cmd_s1.reg_select)
					SEL_ADDR: begin
						rd_byte = ptr_q;
						step_d  = STEP_RED;
					end
					SEL_DATA: begin
						if (step_q != STEP_DONE) begin
							case (step_q)
								STEP_RED:   rd_byte = rd_data[23:16];
								STEP_GREEN: rd_byte = rd_data[15:8];
								default:    rd_byte = rd_data[7:0];
							endcase
							step_d = step_q + 2'd1;
						end
					end
					SEL_PBC: rd_byte = pbc_q;
					default: ;
				endcase
			end
			REQ_WRITE: begin
				case (cmd_s1.reg_select)
					SEL_ADDR: begin
						ptr_d  = cmd_s1.write_data;
						step_d = STEP_RED;
					end
					SEL_DATA: begin
						// a write past blue stores nothing but still moves on
						if (step_q == STEP_DONE || step_q == STEP_BLUE) begin
							step_d = STEP_RED;
							ptr_d  = ptr_q + 8'd1;
						end else begin
							step_d = step_q + 2'd1;
						end
						if (step_q != STEP_DONE) begin
							wr_en = !mono_q || step_q == STEP_BLUE;
						end
					end
					SEL_PBC: begin
						pbc_d = cmd_s1.write_data;
						case (cmd_s1.write_data[4:2])
							PBC_1BPP:  depth_d = DEPTH_1BPP;
							PBC_2BPP:  depth_d = DEPTH_2BPP;
							PBC_4BPP:  depth_d = DEPTH_4BPP;
							PBC_8BPP:  depth_d = DEPTH_8BPP;
							PBC_24BPP: depth_d = DEPTH_24BPP;
							default:   depth_d = depth_q;
						endcase
					end
					default: ;
				endcase
			end
			REQ_LOOKUP: color = rd_data;
			default: ;
		endcase
	end

	always_comb begin
		wr_req.en   = busy_q && wr_en;
		wr_req.addr = ptr_q;
		// mono: the blue byte lands in all three channels
		wr_req.data = mono_q ? {3{cmd_s1.write_data}} : merged;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (busy_q) begin
			rsp_q.read_data   <= rd_byte;
			rsp_q.pixel_color <= color;
			rsp_q.depth_mode  <= depth_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			mono_q  <= 1'b0;
			ptr_q   <= '0;
			step_q  <= STEP_RED;
			pbc_q   <= '0;
			depth_q <= DEPTH_1BPP;
		end else begin
			if (cfg_we) begin
				mono_q <= cfg_wdata;
			end
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				ptr_q   <= ptr_d;
				step_q  <= step_d;
				pbc_q   <= pbc_d;
				depth_q <= depth_d;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/palette_dac_register_interface.sv =====
// Palette DAC register interface, top level: sequencer plus palette RAM.
// Depends on pdri_pkg, pdri_ctrl and pdri_palette_ram.
//
// A command word is taken when start is high and busy is low. busy is high
// in the cycle after that while the palette RAM read completes and the
// entry is modified and written back; the result word shows on rsp with done
// high for exactly one cycle after that, and must be taken then, since the
// receiver cannot hold it off. A new command can be accepted in the same cycle
// as the previous done, but not while busy is high: the RAM read issued on
// acceptance lands in the busy cycle, and the merged entry is written back
// there before the next word's read can start. Register reads, writes and
// pixel lookups all follow the same sequence. No clearing pass is needed
// after reset: each palette entry has a valid bit, unwritten entries read as
// black. cfg_we may only be pulsed while the block is idle.
module palette_dac_register_interface #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pdri_pkg::pdri_cmd_t  cmd,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	output logic                 done,
	output pdri_pkg::pdri_rsp_t  rsp
);
	import pdri_pkg::*;

	pdri_rd_t           rd_req;
	pdri_wr_t           wr_req;
	logic [COLOR_W-1:0] rd_data;

	pdri_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp),
		.rd_req    (rd_req),
		.wr_req    (wr_req),
		.rd_data   (rd_data)
	);

	pdri_palette_ram #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_req  (rd_req),
		.wr_req  (wr_req),
		.rd_data (rd_data)
	);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("result word missing after busy cycle");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_req.en |-> busy)
		else $error("palette write outside the modify cycle");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.depth_mode <= DEPTH_24BPP)
		else $error("depth mode out of range");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.read_data == '0 || rsp.pixel_color == '0))
		else $error("read data and pixel color both set");
`endif

endmodule

// ===== test/pdri_checker.sv =====
// Result checker for the palette DAC register interface testbench.
// Depends on pdri_pkg; watches the command, config and result channels of the block.
module pdri_checker #(
	parameter int ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  pdri_pkg::pdri_cmd_t cmd,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                done,
	input  pdri_pkg::pdri_rsp_t rsp,
	output int                  mismatches,
	output int                  outstanding
);
	import pdri_pkg::*;

	logic [23:0] palette [256];
	logic [7:0]  pointer;
	logic [1:0]  step;
	logic [7:0]  pbc;
	logic [2:0]  depth;
	logic        mono;

	pdri_rsp_t expected_words [$];
	pdri_rsp_t want;

	function automatic logic [23:0] entry_color(input logic [7:0] idx);
		if (int'(idx) >= ENTRIES) begin
			return 24'd0;
		end
		return palette[idx];
	endfunction

	// advance red -> green -> blue, then on to the next entry
	function automatic void next_component();
		if (step == STEP_BLUE) begin
			step = STEP_RED;
			pointer = pointer + 8'd1;
		end else begin
			step = step + 2'd1;
		end
	endfunction

	// applies one command word to the shadow state, returns the result word it causes
	function automatic pdri_rsp_t palette_access(input pdri_cmd_t c);
		pdri_rsp_t r;
		logic [23:0] e;
		r = '0;
		case (c.req_type)
		REQ_READ: begin
			case (c.reg_select)
			SEL_ADDR: begin
				step = STEP_RED;
				r.read_data = pointer;
			end
			SEL_DATA: begin
				if (step != STEP_DONE) begin
					e = entry_color(pointer);
					case (step)
					STEP_RED:   r.read_data = e[23:16];
					STEP_GREEN: r.read_data = e[15:8];
					default:    r.read_data = e[7:0];
					endcase
					step = step + 2'd1;
				end
			end
			SEL_PBC: r.read_data = pbc;
			default: ;
			endcase
		end
		REQ_WRITE: begin
			case (c.reg_select)
			SEL_ADDR: begin
				pointer = c.write_data;
				step = STEP_RED;
			end
			SEL_DATA: begin
				if (step == STEP_DONE) begin
					// stale step: nothing stored, skip to next entry
					step = STEP_RED;
					pointer = pointer + 8'd1;
				end else begin
					if (int'(pointer) < ENTRIES) begin
						if (mono) begin
							if (step == STEP_BLUE) begin
								palette[pointer] = {3{c.write_data}};
							end
						end else begin
							case (step)
							STEP_RED:   palette[pointer][23:16] = c.write_data;
							STEP_GREEN: palette[pointer][15:8] = c.write_data;
							default:    palette[pointer][7:0] = c.write_data;
							endcase
						end
					end
					next_component();
				end
			end
			SEL_PBC: begin
				pbc = c.write_data;
				case (c.write_data[4:2])
				PBC_1BPP:  depth = DEPTH_1BPP;
				PBC_2BPP:  depth = DEPTH_2BPP;
				PBC_4BPP:  depth = DEPTH_4BPP;
				PBC_8BPP:  depth = DEPTH_8BPP;
				PBC_24BPP: depth = DEPTH_24BPP;
				default: ;
				endcase
			end
			default: ;
			endcase
		end
		REQ_LOOKUP: r.pixel_color = entry_color(c.pixel_index);
		default: ;
		endcase
		r.depth_mode = depth;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) begin
				palette[i] = 24'd0;
			end
			pointer = 8'd0;
			step = STEP_RED;
			pbc = 8'd0;
			depth = DEPTH_1BPP;
			mono = 1'b0;
			expected_words.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// the result of the previous word may land on the edge that takes the next one
			if (done) begin
				if (expected_words.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (rsp.read_data !== want.read_data) begin
						$error("read_data: expected %0h, got %0h", want.read_data, rsp.read_data);
						mismatches++;
					end
					if (rsp.pixel_color !== want.pixel_color) begin
						$error("pixel_color: expected %0h, got %0h",
							want.pixel_color, rsp.pixel_color);
						mismatches++;
					end
					if (rsp.depth_mode !== want.depth_mode) begin
						$error("depth_mode: expected %0d, got %0d",
							want.depth_mode, rsp.depth_mode);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				mono = cfg_wdata;
			end
			if (start && !busy) begin
				expected_words.push_back(palette_access(cmd));
			end
			outstanding = expected_words.size();
		end
	end

endmodule

// ===== test/palette_dac_register_interface_test.sv =====
// Testbench top for the palette DAC register interface: clock, reset, stimulus, verdict.
// Depends on pdri_pkg, the block under test and pdri_checker.
module palette_dac_register_interface_test;
	import pdri_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [1:0] SEL_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	pdri_cmd_t cmd;
	logic      cfg_we;
	logic      cfg_wdata;
	logic      done;
	pdri_rsp_t rsp;

	int mismatches;
	int outstanding;
	int cycles;
	int burst_left;
	int counted;
	logic [7:0] last_addr;

	palette_dac_register_interface uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	pdri_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("[palette_dac_register_interface] ERROR");
			$finish;
		end
	end

	function automatic pdri_cmd_t mk(input logic [1:0] req, input logic [1:0] sel,
		input logic [7:0] data, input logic [7:0] pix);
		pdri_cmd_t c;
		c.req_type = req;
		c.reg_select = sel;
		c.write_data = data;
		c.pixel_index = pix;
		return c;
	endfunction

	// start stays high across a burst; a gap of idle cycles opens each new burst
	task automatic issue(input pdri_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			start <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 6);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		burst_left--;
		if (c.req_type != REQ_NONE && (c.req_type == REQ_LOOKUP || c.reg_select != SEL_NONE)) begin
			counted++;
		end
	endtask

	task automatic quiesce();
		start <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mono(input logic v);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int amount);
		int goal;
		int n;
		logic [7:0] a;
		goal = counted + amount;
		while (counted < goal) begin
			case ($urandom_range(0, 9))
			0, 1, 2: begin
				// palette load, long runs cross entries and sometimes wrap at 255
				a = ($urandom_range(0, 3) == 0) ? 8'(254 + $urandom_range(0, 1)) : 8'($urandom);
				last_addr = a;
				issue(mk(REQ_WRITE, SEL_ADDR, a, 8'($urandom)));
				n = $urandom_range(3, 10);
				repeat (n) issue(mk(REQ_WRITE, SEL_DATA, 8'($urandom), 8'($urandom)));
			end
			3, 4: begin
				if ($urandom_range(0, 1) == 0) begin
					issue(mk(REQ_WRITE, SEL_ADDR, last_addr, 8'($urandom)));
				end else begin
					issue(mk(REQ_READ, SEL_ADDR, 8'($urandom), 8'($urandom)));
				end
				n = $urandom_range(1, 5);
				repeat (n) issue(mk(REQ_READ, SEL_DATA, 8'($urandom), 8'($urandom)));
				if ($urandom_range(0, 2) == 0) begin
					issue(mk(REQ_WRITE, SEL_DATA, 8'($urandom), 8'($urandom)));
				end
			end
			5, 6: begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					a = ($urandom_range(0, 1) == 0) ? last_addr + 8'($urandom_range(0, 3))
						: 8'($urandom);
					issue(mk(REQ_LOOKUP, 2'($urandom), 8'($urandom), a));
				end
			end
			7: begin
				issue(mk(REQ_WRITE, SEL_PBC, 8'($urandom), 8'($urandom)));
				issue(mk(REQ_READ, SEL_PBC, 8'($urandom), 8'($urandom)));
			end
			default: begin
				n = $urandom_range(1, 3);
				repeat (n) issue(pdri_cmd_t'(20'($urandom)));
			end
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		cycles = 0;
		burst_left = 0;
		counted = 0;
		last_addr = 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_mono(1'b0);
		issue(mk(REQ_LOOKUP, SEL_ADDR, 8'h00, 8'h00));
		issue(mk(REQ_LOOKUP, SEL_ADDR, 8'h00, 8'hff));
		issue(mk(REQ_WRITE, SEL_ADDR, 8'hff, 8'h00));
		issue(mk(REQ_WRITE, SEL_DATA, 8'hff, 8'h00));
		issue(mk(REQ_WRITE, SEL_DATA, 8'h00, 8'h00));
		issue(mk(REQ_WRITE, SEL_DATA, 8'ha5, 8'h00));
		issue(mk(REQ_READ, SEL_ADDR, 8'h00, 8'h00));
		issue(mk(REQ_WRITE, SEL_ADDR, 8'hff, 8'h00));
		repeat (4) issue(mk(REQ_READ, SEL_DATA, 8'h00, 8'h00));
		// write with the step already past blue
		issue(mk(REQ_WRITE, SEL_DATA, 8'h5a, 8'h00));
		issue(mk(REQ_READ, SEL_ADDR, 8'h00, 8'h00));
		issue(mk(REQ_WRITE, SEL_PBC, 8'h1c, 8'h00));
		// undefined depth code keeps the old mode
		issue(mk(REQ_WRITE, SEL_PBC, 8'h04, 8'h00));
		issue(mk(REQ_READ, SEL_PBC, 8'h00, 8'h00));
		issue(mk(REQ_WRITE, SEL_PBC, 8'he3, 8'h00));
		issue(mk(REQ_READ, SEL_NONE, 8'h00, 8'h00));
		issue(mk(REQ_WRITE, SEL_NONE, 8'hff, 8'hff));
		issue(mk(REQ_NONE, SEL_NONE, 8'hff, 8'hff));
		issue(mk(REQ_LOOKUP, SEL_ADDR, 8'h00, 8'hff));

		set_mono(1'b1);
		issue(mk(REQ_WRITE, SEL_ADDR, 8'h10, 8'h00));
		issue(mk(REQ_WRITE, SEL_DATA, 8'h11, 8'h00));
		issue(mk(REQ_WRITE, SEL_DATA, 8'h22, 8'h00));
		issue(mk(REQ_WRITE, SEL_DATA, 8'h33, 8'h00));
		issue(mk(REQ_LOOKUP, SEL_ADDR, 8'h00, 8'h10));
		issue(mk(REQ_READ, SEL_ADDR, 8'h00, 8'h00));

		set_mono(1'b0);
		random_traffic(140);
		set_mono(1'b1);
		random_traffic(140);
		set_mono(1'b0);
		random_traffic(135);
		set_mono(1'b1);
		random_traffic(135);

		quiesce();
		if (mismatches == 0) begin
			$display("[palette_dac_register_interface] OK");
		end else begin
			$display("[palette_dac_register_interface] ERROR");
		end
		$finish;
	end

endmodule

// ===== palette_dac_register_interface.f =====
rtl/pdri_pkg.sv
rtl/pdri_palette_ram.sv
rtl/pdri_ctrl.sv
rtl/palette_dac_register_interface.sv
test/pdri_checker.sv
test/palette_dac_register_interface_test.sv
